### hdl/salc_pkg.sv
// ----------------------------------------------------------------------------
// salc_pkg
// Shared constants, codes and control types of the set-associative cache.
// ----------------------------------------------------------------------------
package salc_pkg;

  localparam int unsigned SetBitsDef      = 6;
  localparam int unsigned WaysDef         = 4;
  localparam int unsigned LineWordBitsDef = 3;

  // Operation codes.
  localparam logic [1:0] OpRead  = 2'd0;
  localparam logic [1:0] OpWrite = 2'd1;
  localparam logic [1:0] OpFill  = 2'd2;
  localparam logic [1:0] OpFlush = 2'd3;

  // Access size codes; the reserved size stores nothing on a write and reads all ones.
  localparam logic [1:0] SizeByte = 2'd0;
  localparam logic [1:0] SizeHalf = 2'd1;
  localparam logic [1:0] SizeWord = 2'd2;
  localparam logic [1:0] SizeRsvd = 2'd3;

  // Result kinds.
  localparam logic KindRead  = 1'b0;
  localparam logic KindFlush = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear;     // reset one set record during the clearing pass
    logic capture;   // latch the input beat and read the set record
    logic data_rd;   // read one data word into the registered read port
    logic update;    // perform read reply or write/fill update
    logic out_load;  // load the output register from the datapath
    logic invalidate;// clear the valid bit of the flushed line
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] op;
    logic       victim_valid;
    logic       flush_last;
    logic       clear_last;
  } dp_stat_t;

endpackage

### hdl/salc_ctrl.sv
// ----------------------------------------------------------------------------
// salc_ctrl
// Controller state machine: sequences lookup, update and flush beats.
// ----------------------------------------------------------------------------
module salc_ctrl
  import salc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       out_ready_i,
  output logic       out_valid_o,
  input  dp_stat_t   stat_i,
  output ctrl_cmd_t  cmd_o
);

  localparam logic [2:0] StInit     = 3'd0;
  localparam logic [2:0] StIdle     = 3'd1;
  localparam logic [2:0] StLookup   = 3'd2;
  localparam logic [2:0] StAccess   = 3'd3;
  localparam logic [2:0] StFlushRd  = 3'd4;
  localparam logic [2:0] StFlushOut = 3'd5;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  // The output register can take a new beat when empty or being drained.
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign in_ready_o  = (state_q == StIdle);

  // Next-state and command logic.
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    unique case (state_q)
      StInit: begin
        // Clearing pass over the set records after reset.
        cmd_o.clear = 1'b1;
        if (stat_i.clear_last) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = StLookup;
        end
      end
      StLookup: begin
        if (stat_i.op == OpFlush) begin
          if (stat_i.victim_valid) begin
            state_d = StFlushRd;
          end else begin
            state_d = StIdle;
          end
        end else begin
          cmd_o.data_rd = 1'b1;
          state_d       = StAccess;
        end
      end
      StAccess: begin
        if (stat_i.op == OpRead) begin
          if (out_free) begin
            cmd_o.update   = 1'b1;
            cmd_o.out_load = 1'b1;
            out_valid_d    = 1'b1;
            state_d        = StIdle;
          end
        end else begin
          cmd_o.update = 1'b1;
          state_d      = StIdle;
        end
      end
      StFlushRd: begin
        // Word read into the registered memory port.
        cmd_o.data_rd = 1'b1;
        state_d       = StFlushOut;
      end
      StFlushOut: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          if (stat_i.flush_last) begin
            cmd_o.invalidate = 1'b1;
            state_d          = StIdle;
          end else begin
            state_d = StFlushRd;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StInit;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

### hdl/salc_datapath.sv
// ----------------------------------------------------------------------------
// salc_datapath
// Set record and data storage, hit detection and output register.
// ----------------------------------------------------------------------------
module salc_datapath
  import salc_pkg::*;
#(
  parameter int unsigned SetBits      = SetBitsDef,
  parameter int unsigned Ways         = WaysDef,
  parameter int unsigned LineWordBits = LineWordBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  ctrl_cmd_t   cmd_i,
  output dp_stat_t    stat_o,
  input  logic [1:0]  operation_i,
  input  logic [31:0] address_i,
  input  logic [31:0] write_data_i,
  input  logic [1:0]  access_size_i,
  output logic        result_kind_o,
  output logic [31:0] read_data_o,
  output logic        read_hit_o,
  output logic [31:0] memory_address_o,
  output logic [31:0] memory_word_o,
  output logic        last_o
);

  localparam int unsigned NSets    = 1 << SetBits;
  localparam int unsigned LWords   = 1 << LineWordBits;
  localparam int unsigned WayBits  = (Ways > 1) ? $clog2(Ways) : 1;
  localparam int unsigned SetShift = LineWordBits + 2;
  localparam int unsigned TagShift = SetBits + LineWordBits + 2;
  localparam int unsigned TagBits  = 32 - TagShift;
  localparam int unsigned LineBits = SetBits + WayBits;
  localparam int unsigned DataAw   = LineBits + LineWordBits;
  localparam int unsigned WcBits   = (LineWordBits > 0) ? LineWordBits : 1;

  typedef logic [WayBits-1:0]             way_t;
  typedef logic [Ways-1:0][WayBits-1:0]   order_t;
  typedef logic [Ways-1:0][TagBits-1:0]   tags_t;
  typedef logic [Ways-1:0][LWords-1:0]    mask_t;

  // Set records (valid bits, recency order, tags, written-word masks) and data.
  logic [Ways-1:0] valid_mem [NSets];
  order_t          order_mem [NSets];
  tags_t           tag_mem   [NSets];
  mask_t           mask_mem  [NSets];
  logic [31:0]     data_mem  [1 << DataAw];

  // Captured input beat.
  logic [1:0]         op_q;
  logic [1:0]         size_q;
  logic [31:0]        wdata_q;
  logic [SetBits-1:0] set_q;
  logic [TagBits-1:0] tag_q;
  logic [WcBits-1:0]  wid_q;
  logic [1:0]         boff_q;

  // Set record registered after capture, data word read port and counters.
  logic [Ways-1:0]    valid_rd_q;
  order_t             order_rd_q;
  tags_t              tags_rd_q;
  mask_t              mask_rd_q;
  logic [31:0]        word_q;
  logic [WcBits-1:0]  wc_q;
  logic [SetBits-1:0] clr_q;

  // Input field split.
  logic [SetBits-1:0] in_set;
  logic [WcBits-1:0]  in_wid;
  assign in_set = address_i[SetShift +: SetBits];
  if (LineWordBits > 0) begin : g_wid
    assign in_wid = address_i[2 +: LineWordBits];
  end else begin : g_nowid
    assign in_wid = 1'b0;
  end

  function automatic logic [DataAw-1:0] daddr(logic [SetBits-1:0] s, way_t w,
                                              logic [WcBits-1:0] i);
    logic [DataAw-1:0] a;
    a = {s, w, {LineWordBits{1'b0}}};
    if (LineWordBits > 0) a[LineWordBits-1:0] = i[LineWordBits-1:0];
    return a;
  endfunction

  // Capture the beat and read the record of its set.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q       <= operation_i;
      size_q     <= access_size_i;
      wdata_q    <= write_data_i;
      set_q      <= in_set;
      tag_q      <= address_i[31 -: TagBits];
      wid_q      <= in_wid;
      boff_q     <= address_i[1:0];
      valid_rd_q <= valid_mem[in_set];
      order_rd_q <= order_mem[in_set];
      tags_rd_q  <= tag_mem[in_set];
      mask_rd_q  <= mask_mem[in_set];
    end
  end

  // Hit detection.
  logic [Ways-1:0] hit_vec;
  logic            hit;
  way_t            hit_way, victim, use_way;
  always_comb begin
    hit_way = '0;
    for (int w = 0; w < Ways; w++) begin
      hit_vec[w] = valid_rd_q[w] && (tags_rd_q[w] == tag_q);
    end
    for (int w = Ways - 1; w >= 0; w--) begin
      if (hit_vec[w]) hit_way = way_t'(w);
    end
    hit     = |hit_vec;
    victim  = order_rd_q[0];
    use_way = hit ? hit_way : victim;
  end

  // New recency order with use_way moved to the most recent end.
  order_t new_order;
  always_comb begin
    logic seen;
    seen = 1'b0;
    for (int k = 0; k < Ways; k++) begin
      if (order_rd_q[k] == use_way) seen = 1'b1;
      if (k == Ways - 1) new_order[k] = use_way;
      else new_order[k] = seen ? order_rd_q[k+1] : order_rd_q[k];
    end
  end

  // Recency order of a freshly reset set.
  order_t ident_order;
  always_comb begin
    for (int w = 0; w < Ways; w++) ident_order[w] = way_t'(w);
  end

  // Word selection and merging; a word not written since allocation is zero.
  logic [1:0]  hoff;
  logic [31:0] old_word, merged, rd_val, fl_word;
  assign hoff     = (boff_q == 2'd3) ? 2'd2 : boff_q;
  assign old_word = (hit && mask_rd_q[use_way][wid_q]) ? word_q : 32'd0;
  assign fl_word  = mask_rd_q[victim][wc_q] ? word_q : 32'd0;
  always_comb begin
    merged = old_word;
    rd_val = 32'hffffffff;
    case (size_q)
      SizeByte: begin
        merged[8*boff_q +: 8] = wdata_q[7:0];
        rd_val = {24'd0, old_word[8*boff_q +: 8]};
      end
      SizeHalf: begin
        merged[8*hoff +: 16] = wdata_q[15:0];
        rd_val = {16'd0, old_word[8*hoff +: 16]};
      end
      SizeWord: begin
        merged = wdata_q;
        rd_val = old_word;
      end
      default: ;
    endcase
    if (op_q == OpFill) merged = wdata_q;
  end

  logic is_wr;
  assign is_wr = cmd_i.update && (op_q != OpRead);

  // Data memory: one write port and one registered read port.
  logic [DataAw-1:0] rd_addr, wr_addr;
  assign wr_addr = daddr(set_q, use_way, wid_q);
  assign rd_addr = (op_q == OpFlush) ? daddr(set_q, victim, wc_q) : wr_addr;
  always_ff @(posedge clk_i) begin
    if (is_wr) data_mem[wr_addr] <= merged;
    if (cmd_i.data_rd) word_q <= data_mem[rd_addr];
  end

  // Updated set record after an access or a flush.
  logic [Ways-1:0] valid_new;
  order_t          order_new;
  tags_t           tags_new;
  mask_t           mask_new;
  logic            rec_we;
  assign rec_we = (cmd_i.update && (op_q != OpRead || hit)) || cmd_i.invalidate;
  always_comb begin
    valid_new = valid_rd_q;
    order_new = order_rd_q;
    tags_new  = tags_rd_q;
    mask_new  = mask_rd_q;
    if (cmd_i.invalidate) begin
      valid_new[victim] = 1'b0;
    end else begin
      order_new = new_order;
      if (op_q != OpRead) begin
        valid_new[use_way] = 1'b1;
        if (!hit) begin
          tags_new[use_way] = tag_q;
          mask_new[use_way] = '0;
        end
        if (!(op_q == OpWrite && size_q == SizeRsvd)) begin
          mask_new[use_way][wid_q] = 1'b1;
        end
      end
    end
  end

  // Set record write port, shared with the clearing pass after reset.
  always_ff @(posedge clk_i) begin
    if (cmd_i.clear) begin
      valid_mem[clr_q] <= '0;
      order_mem[clr_q] <= ident_order;
      mask_mem[clr_q]  <= '0;
    end else if (rec_we) begin
      valid_mem[set_q] <= valid_new;
      order_mem[set_q] <= order_new;
      tag_mem[set_q]   <= tags_new;
      mask_mem[set_q]  <= mask_new;
    end
  end

  // Flush word counter and clearing pass counter.
  logic flush_last;
  assign flush_last = (wc_q == WcBits'(LWords - 1));
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wc_q  <= '0;
      clr_q <= '0;
    end else begin
      if (cmd_i.clear) clr_q <= clr_q + 1'b1;
      if (cmd_i.out_load && op_q == OpFlush) begin
        wc_q <= flush_last ? '0 : WcBits'(wc_q + 1'b1);
      end
    end
  end

  assign stat_o.op           = op_q;
  assign stat_o.victim_valid = valid_rd_q[victim];
  assign stat_o.flush_last   = flush_last;
  assign stat_o.clear_last   = (clr_q == '1);

  // Output register.
  logic [31:0] base;
  assign base = {tags_rd_q[victim], set_q, {SetShift{1'b0}}};
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      if (op_q == OpFlush) begin
        result_kind_o    <= KindFlush;
        read_data_o      <= 32'd0;
        read_hit_o       <= 1'b0;
        memory_address_o <= base + (32'(wc_q) << 2);
        memory_word_o    <= fl_word;
        last_o           <= flush_last;
      end else begin
        result_kind_o    <= KindRead;
        read_hit_o       <= hit;
        memory_address_o <= 32'd0;
        memory_word_o    <= 32'd0;
        last_o           <= 1'b1;
        read_data_o      <= hit ? rd_val : 32'hffffffff;
      end
    end
  end

endmodule

### hdl/set_assoc_lru_cache_unit.sv
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_unit
// Set-associative write-allocate cache with per-set LRU replacement.
// ----------------------------------------------------------------------------
// Usage: an input beat (operation, address, write_data, access_size) is taken
// on in_valid_i && in_ready_o, and one item is handled at a time. Reads return
// one result beat; writes and fills return none; a flush of a valid
// least-recent line returns one memory-write beat per line word, last_o
// marking the final one, and a flush of an invalid line returns nothing.
// Sequence: a read, write or fill goes through set record read, data word read,
// then update; the read reply is loaded into the output register by the update
// step, and in_ready_o returns with it. A flush looks up the set and then
// reads each word through the registered data-memory read port and loads it
// out; a flush of an invalid line ends after the lookup.
// Reset starts a clearing pass over all 2^SetBits sets (64 by default) that
// clears the valid bits and restores the recency order of every set; in_ready_o
// stays low during it. When the receiver stalls, the result holds and the
// controller waits, with in_ready_o low, before loading the next one.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_unit
  import salc_pkg::*;
#(
  parameter int unsigned SetBits      = SetBitsDef,
  parameter int unsigned Ways         = WaysDef,
  parameter int unsigned LineWordBits = LineWordBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  operation_i,
  input  logic [31:0] address_i,
  input  logic [31:0] write_data_i,
  input  logic [1:0]  access_size_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        result_kind_o,
  output logic [31:0] read_data_o,
  output logic        read_hit_o,
  output logic [31:0] memory_address_o,
  output logic [31:0] memory_word_o,
  output logic        last_o
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  salc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  salc_datapath #(
    .SetBits      (SetBits),
    .Ways         (Ways),
    .LineWordBits (LineWordBits)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .operation_i      (operation_i),
    .address_i        (address_i),
    .write_data_i     (write_data_i),
    .access_size_i    (access_size_i),
    .result_kind_o    (result_kind_o),
    .read_data_o      (read_data_o),
    .read_hit_o       (read_hit_o),
    .memory_address_o (memory_address_o),
    .memory_word_o    (memory_word_o),
    .last_o           (last_o)
  );

endmodule

### test/set_assoc_lru_cache_unit_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_unit_checker
// Watches both channels of the cache, keeps its own copy of tags, data,
// valid bits and recency order, and compares every result beat.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_unit_checker
  import salc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [1:0]  operation_i,
  input  logic [31:0] address_i,
  input  logic [31:0] write_data_i,
  input  logic [1:0]  access_size_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic        result_kind_i,
  input  logic [31:0] read_data_i,
  input  logic        read_hit_i,
  input  logic [31:0] memory_address_i,
  input  logic [31:0] memory_word_i,
  input  logic        last_i,
  output int          errors_o,
  output int          pending_o
);

  localparam int NSets  = 1 << SetBitsDef;
  localparam int NWays  = WaysDef;
  localparam int NWords = 1 << LineWordBitsDef;
  localparam int SetLo  = LineWordBitsDef + 2;
  localparam int TagLo  = SetBitsDef + LineWordBitsDef + 2;

  typedef struct packed {
    logic        kind;
    logic [31:0] rdata;
    logic        hit;
    logic [31:0] maddr;
    logic [31:0] mword;
    logic        last;
  } cache_beat_t;

  logic [31:0] words_q [NSets][NWays][NWords];
  logic [31:0] tags_q  [NSets][NWays];
  logic        valid_q [NSets][NWays];
  int          order_q [NSets][NWays];
  cache_beat_t replies_q [$];

  // Model state after reset.
  function automatic void reset_model();
    for (int s = 0; s < NSets; s++)
      for (int w = 0; w < NWays; w++) begin
        valid_q[s][w] = 1'b0;
        tags_q[s][w] = '0;
        order_q[s][w] = w;
        for (int i = 0; i < NWords; i++) words_q[s][w][i] = '0;
      end
  endfunction

  // Move a way to the most recent end of its set's order.
  function automatic void touch_way(int s, int w);
    int p;
    p = 0;
    while (p < NWays && order_q[s][p] != w) p++;
    if (p >= NWays) p = NWays - 1;
    for (int k = p; k + 1 < NWays; k++) order_q[s][k] = order_q[s][k + 1];
    order_q[s][NWays - 1] = w;
  endfunction

  function automatic int lookup_way(int s, logic [31:0] tag);
    for (int w = 0; w < NWays; w++)
      if (valid_q[s][w] && tags_q[s][w] == tag) return w;
    return -1;
  endfunction

  // Hit or allocate a zeroed line; the way ends up most recent.
  function automatic int claim_way(int s, logic [31:0] tag);
    int w;
    w = lookup_way(s, tag);
    if (w < 0) begin
      w = order_q[s][0];
      for (int i = 0; i < NWords; i++) words_q[s][w][i] = '0;
      tags_q[s][w] = tag;
      valid_q[s][w] = 1'b1;
    end
    touch_way(s, w);
    return w;
  endfunction

  function automatic void predict_access(logic [1:0] op, logic [31:0] addr,
                                         logic [31:0] wdata, logic [1:0] size);
    int s, wi, w, boff, hoff;
    logic [31:0] tag, val;
    cache_beat_t b;
    s = int'(addr[SetLo +: SetBitsDef]);
    tag = addr >> TagLo;
    wi = int'(addr[2 +: LineWordBitsDef]);
    boff = int'(addr[1:0]);
    hoff = (boff == 3) ? 2 : boff;
    case (op)
      OpRead: begin
        w = lookup_way(s, tag);
        val = '1;
        if (w >= 0) begin
          touch_way(s, w);
          if (size == SizeByte) val = (words_q[s][w][wi] >> (8 * boff)) & 32'hff;
          else if (size == SizeHalf) val = (words_q[s][w][wi] >> (8 * hoff)) & 32'hffff;
          else if (size == SizeWord) val = words_q[s][w][wi];
        end
        b = '{KindRead, val, (w >= 0), 32'd0, 32'd0, 1'b1};
        replies_q.push_back(b);
      end
      OpWrite: begin
        w = claim_way(s, tag);
        if (size == SizeByte)
          words_q[s][w][wi] = (words_q[s][w][wi] & ~(32'hff << (8 * boff)))
                              | ((wdata & 32'hff) << (8 * boff));
        else if (size == SizeHalf)
          words_q[s][w][wi] = (words_q[s][w][wi] & ~(32'hffff << (8 * hoff)))
                              | ((wdata & 32'hffff) << (8 * hoff));
        else if (size == SizeWord)
          words_q[s][w][wi] = wdata;
      end
      OpFill: begin
        w = claim_way(s, tag);
        words_q[s][w][wi] = wdata;
      end
      default: begin
        w = order_q[s][0];
        if (valid_q[s][w]) begin
          for (int i = 0; i < NWords; i++) begin
            b = '{KindFlush, 32'd0, 1'b0,
                  (tags_q[s][w] << TagLo) | (s << SetLo) | (i * 4),
                  words_q[s][w][i], (i == NWords - 1)};
            replies_q.push_back(b);
          end
          valid_q[s][w] = 1'b0;
        end
      end
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    errors_o++;
  endtask

  // Predict on each input beat, compare on each output beat.
  always @(posedge clk_i) begin
    cache_beat_t e;
    if (!rst_ni) begin
      errors_o = 0;
      replies_q.delete();
      reset_model();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (replies_q.size() == 0) begin
          report_mismatch("unexpected beat", memory_address_i, 32'd0);
        end else begin
          e = replies_q.pop_front();
          if (result_kind_i !== e.kind) report_mismatch("result_kind", result_kind_i, e.kind);
          if (read_data_i !== e.rdata) report_mismatch("read_data", read_data_i, e.rdata);
          if (read_hit_i !== e.hit) report_mismatch("read_hit", read_hit_i, e.hit);
          if (memory_address_i !== e.maddr)
            report_mismatch("memory_address", memory_address_i, e.maddr);
          if (memory_word_i !== e.mword)
            report_mismatch("memory_word", memory_word_i, e.mword);
          if (last_i !== e.last) report_mismatch("last", last_i, e.last);
        end
      end
      if (in_valid_i && in_ready_i)
        predict_access(operation_i, address_i, write_data_i, access_size_i);
    end
    pending_o = replies_q.size();
  end

endmodule

### test/set_assoc_lru_cache_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_unit_tb
// Drives reads, writes, fills and flushes with bursty input and a stalling
// receiver; the checker predicts and compares every result beat.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_unit_tb;
  import salc_pkg::*;

  localparam int SetLo     = LineWordBitsDef + 2;
  localparam int TagLo     = SetBitsDef + LineWordBitsDef + 2;
  localparam int TagBits   = 32 - TagLo;
  localparam int IdleLimit = 5000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  operation_i = OpRead;
  logic [31:0] address_i = '0;
  logic [31:0] write_data_i = '0;
  logic [1:0]  access_size_i = SizeByte;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        result_kind_o;
  logic [31:0] read_data_o;
  logic        read_hit_o;
  logic [31:0] memory_address_o;
  logic [31:0] memory_word_o;
  logic        last_o;
  int          errors;
  int          pending;
  bit          hold_req = 1'b0;
  int          idle_cycles = 0;

  set_assoc_lru_cache_unit uut (.*);

  set_assoc_lru_cache_unit_checker checker_i (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .operation_i, .address_i,
    .write_data_i, .access_size_i, .out_valid_i(out_valid_o), .out_ready_i,
    .result_kind_i(result_kind_o), .read_data_i(read_data_o), .read_hit_i(read_hit_o),
    .memory_address_i(memory_address_o), .memory_word_i(memory_word_o),
    .last_i(last_o), .errors_o(errors), .pending_o(pending)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Build an address from a small tag pool so that sets see reuse.
  function automatic logic [31:0] pick_address(int set_sel);
    logic [31:0] a;
    a = $urandom;
    if ($urandom_range(0, 3) != 0) begin
      a[31:TagLo] = TagBits'($urandom_range(0, 5) * 32'h0015_5555);
      a[SetLo +: SetBitsDef] = SetBitsDef'(set_sel);
    end
    return a;
  endfunction

  // Offer one beat at a falling edge and return at the falling edge after
  // the rising edge that takes it.
  task automatic send_beat(logic [1:0] op, logic [31:0] addr, logic [31:0] data,
                           logic [1:0] size);
    in_valid_i <= 1'b1;
    operation_i <= op;
    address_i <= addr;
    write_data_i <= data;
    access_size_i <= size;
    while (!in_ready_o) @(negedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic pause_sender(int cycles);
    in_valid_i <= 1'b0;
    repeat (cycles) @(negedge clk_i);
  endtask

  // Receiver stall pattern, with one long hold while the sender runs.
  initial begin
    int mode;
    bit hold_seen;
    mode = 0;
    hold_seen = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        out_ready_i <= 1'b0;
        repeat (60) @(negedge clk_i);
      end
      if ($urandom_range(0, 49) == 0) mode = $urandom_range(0, 2);
      case (mode)
        0: out_ready_i <= 1'b1;
        1: out_ready_i <= ($urandom_range(0, 2) != 0);
        default: out_ready_i <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Watchdog on cycles without any accepted beat.
  initial begin
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    logic [31:0] base;
    int s, burst, opsel;
    logic [1:0] op;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: empty read, flush of an empty set, every size and offset.
    base = 32'hffff_ffff;
    send_beat(OpRead, base, '0, SizeWord);
    send_beat(OpFlush, base, '0, SizeWord);
    send_beat(OpFill, base, 32'hffff_ffff, SizeWord);
    send_beat(OpWrite, base, 32'h0000_0000, SizeByte);
    for (int o = 0; o < 4; o++) begin
      send_beat(OpRead, {base[31:2], 2'(o)}, '0, SizeByte);
      send_beat(OpRead, {base[31:2], 2'(o)}, '0, SizeHalf);
    end
    send_beat(OpWrite, base - 1, 32'h1234_5678, SizeHalf);
    send_beat(OpWrite, base, 32'h0, SizeRsvd);
    send_beat(OpRead, base, '0, SizeRsvd);
    send_beat(OpRead, base, '0, SizeWord);
    // Five tags in set 0 force an eviction, then flush the oldest.
    for (int t = 0; t < 5; t++)
      send_beat(OpWrite, (t << TagLo) | (t * 4), 32'hA5A5_0000 + t, SizeWord);
    send_beat(OpRead, 32'h0, '0, SizeWord);
    send_beat(OpRead, 1 << TagLo, '0, SizeWord);
    send_beat(OpFlush, 32'h0, '0, SizeByte);
    send_beat(OpFlush, 32'h0, '0, SizeByte);

    // Hold the receiver while read hits keep coming in.
    hold_req = ~hold_req;
    for (int i = 0; i < 6; i++) send_beat(OpRead, 1 << TagLo, '0, SizeWord);

    // Random bursts, biased toward a few sets and tags.
    for (int n = 0; n < 250;) begin
      burst = $urandom_range(1, 12);
      for (int k = 0; k < burst; k++, n++) begin
        s = $urandom_range(0, 3);
        opsel = $urandom_range(0, 9);
        op = (opsel < 3) ? OpRead : (opsel < 6) ? OpWrite : (opsel < 8) ? OpFill : OpFlush;
        send_beat(op, pick_address(s), $urandom, 2'($urandom_range(0, 3)));
      end
      if (n > 120 && n < 135) begin
        in_valid_i <= 1'b0;
        while (pending != 0) @(negedge clk_i);
      end
      if ($urandom_range(0, 2) != 0) pause_sender($urandom_range(1, 15));
    end
    in_valid_i <= 1'b0;

    while (pending != 0) @(negedge clk_i);
    repeat (30) @(negedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
